@@ sv/cpvc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpvc_pkg
// Shared constants and types for the convex polygon validity checker.
// ----------------------------------------------------------------------------
package cpvc_pkg;

  localparam int MAX_VERTS = 8;
  localparam int IDX_W     = $clog2(MAX_VERTS);
  localparam int CNT_W     = 4;
  localparam int RAW_SAT   = 15;
  localparam int COORD_W   = 32;
  localparam int VERT_W    = 2 * COORD_W;
  localparam int REG_W     = 64;

  typedef enum logic [0:0] {
    CFG_WELD = 1'b0,
    CFG_EDGE = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    STAT_OK    = 3'd0,
    STAT_COUNT = 3'd1,
    STAT_FEW   = 3'd2,
    STAT_OVF   = 3'd3,
    STAT_DEGEN = 3'd4,
    STAT_SHORT = 3'd5
  } status_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_W_RD,
    ST_W_DIFF,
    ST_W_M1,
    ST_W_M2,
    ST_W_CMP,
    ST_WRITE,
    ST_E_CHK,
    ST_F_CMP,
    ST_H_TOP,
    ST_H_FIRST,
    ST_H_J,
    ST_H_CA,
    ST_H_CB,
    ST_H_CS,
    ST_H_L1,
    ST_H_L2,
    ST_H_L3,
    ST_H_L4,
    ST_H_LC,
    ST_H_NEXT,
    ST_H_ED,
    ST_H_E1,
    ST_H_E2,
    ST_H_EC,
    ST_H_FIN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [VERT_W-1:0] wr_data;
  } ram_req_t;

endpackage

@@ sv/convex_polygon_validity_check.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// convex_polygon_validity_check
// Welds incoming vertices and checks the gift-wrapped hull of the polygon.
// ----------------------------------------------------------------------------
// One word at a time is taken. Each vertex is compared against the kept
// vertices in turn (one store read and two passes through the shared 32x32
// multiplier per comparison). The closing word then runs the hull search: a
// pass over the store to find the start point, then the hull steps, bound by
// the single store read port and the shared multiplier. The result is held in
// an output register.
module convex_polygon_validity_check (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // vert_x[31:0], vert_y[63:32]
  input  logic        in_tlast,   // last_vertex
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // is_valid[0], status[3:1], hull_count[7:4]
  input  logic        cfg_we,
  input  logic [0:0]  cfg_addr,
  input  logic [cpvc_pkg::REG_W-1:0] cfg_wdata
);

  localparam int IW = cpvc_pkg::IDX_W;
  localparam int CW = cpvc_pkg::CNT_W;

  cpvc_pkg::state_t  state_r, state_nxt;
  cpvc_pkg::ram_req_t req;
  logic [63:0] rd_data;
  logic [31:0] rd_x, rd_y;

  logic [63:0] weld_r, edge_r;
  logic [31:0] x_r, x_nxt, y_r, y_nxt;
  logic        last_r, last_nxt;
  logic [CW-1:0] raw_r, raw_nxt, dc_r, dc_nxt, m_r, m_nxt;
  logic [IW-1:0] j_r, j_nxt, ie_r, ie_nxt, ih_r, ih_nxt, i0_r, i0_nxt;
  logic [31:0] ra_r, ra_nxt, rb_r, rb_nxt, va_r, va_nxt, vb_r, vb_nxt;
  logic        rxn_r, rxn_nxt, ryn_r, ryn_nxt, vxn_r, vxn_nxt, vyn_r, vyn_nxt;
  logic [63:0] p1_r, p1_nxt, p2_r, p2_nxt;
  logic [64:0] sv_r, sv_nxt;
  logic [31:0] hx_r, hx_nxt, hy_r, hy_nxt, ex_r, ex_nxt, ey_r, ey_nxt;
  logic        short_r, short_nxt;
  cpvc_pkg::status_t stat_r, stat_nxt;
  logic        out_vld_r, out_vld_nxt;
  logic        o_valid_r, o_valid_nxt;
  logic [2:0]  o_stat_r, o_stat_nxt;
  logic [3:0]  o_hull_r, o_hull_nxt;

  logic signed [32:0] d_wx, d_wy, d_rx, d_ry, d_vx, d_vy;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [64:0] sum;
  logic        lastj, better, n1, n2, c_neg, c_zero;

  function automatic logic [31:0] mag33(input logic signed [32:0] d);
    logic signed [32:0] n;
    n = -d;
    return d[32] ? n[31:0] : d[31:0];
  endfunction

  function automatic logic signed [32:0] sx(input logic [31:0] v);
    return $signed({v[31], v});
  endfunction

  cpvc_vert_ram u_ram (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  assign rd_x = rd_data[63:32];
  assign rd_y = rd_data[31:0];
  assign d_wx = sx(x_r) - sx(rd_x);
  assign d_wy = sx(y_r) - sx(rd_y);
  assign d_rx = sx(ex_r) - sx(hx_r);
  assign d_ry = sx(ey_r) - sx(hy_r);
  assign d_vx = sx(rd_x) - sx(hx_r);
  assign d_vy = sx(rd_y) - sx(hy_r);
  assign sum  = {1'b0, p1_r} + {1'b0, p2_r};
  assign prod = mul_a * mul_b;
  assign lastj = ({1'b0, j_r} == (dc_r - 4'd1));
  assign better = (j_r == '0) || ($signed(rd_x) > $signed(hx_r)) ||
                  ((rd_x == hx_r) && ($signed(rd_y) < $signed(hy_r)));
  assign n1 = (p1_r != 64'd0) && (rxn_r ^ vyn_r);
  assign n2 = (p2_r != 64'd0) && (ryn_r ^ vxn_r);

  always_comb begin
    if (n1 != n2) begin
      c_neg  = n1;
      c_zero = 1'b0;
    end else if (p1_r == p2_r) begin
      c_neg  = 1'b0;
      c_zero = 1'b1;
    end else begin
      c_neg  = n1 ? (p1_r > p2_r) : (p1_r < p2_r);
      c_zero = 1'b0;
    end
  end

  always_comb begin
    case (state_r)
      cpvc_pkg::ST_W_M1: begin mul_a = ra_r; mul_b = ra_r; end
      cpvc_pkg::ST_W_M2: begin mul_a = rb_r; mul_b = rb_r; end
      cpvc_pkg::ST_H_CA: begin mul_a = ra_r; mul_b = vb_r; end
      cpvc_pkg::ST_H_CB: begin mul_a = rb_r; mul_b = va_r; end
      cpvc_pkg::ST_H_L1: begin mul_a = va_r; mul_b = va_r; end
      cpvc_pkg::ST_H_L2: begin mul_a = vb_r; mul_b = vb_r; end
      cpvc_pkg::ST_H_L3: begin mul_a = ra_r; mul_b = ra_r; end
      cpvc_pkg::ST_H_L4: begin mul_a = rb_r; mul_b = rb_r; end
      cpvc_pkg::ST_H_E1: begin mul_a = ra_r; mul_b = ra_r; end
      cpvc_pkg::ST_H_E2: begin mul_a = rb_r; mul_b = rb_r; end
      default:           begin mul_a = ra_r; mul_b = rb_r; end
    endcase
  end

  assign in_tready = (state_r == cpvc_pkg::ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    x_nxt = x_r; y_nxt = y_r; last_nxt = last_r;
    raw_nxt = raw_r; dc_nxt = dc_r; m_nxt = m_r;
    j_nxt = j_r; ie_nxt = ie_r; ih_nxt = ih_r; i0_nxt = i0_r;
    ra_nxt = ra_r; rb_nxt = rb_r; va_nxt = va_r; vb_nxt = vb_r;
    rxn_nxt = rxn_r; ryn_nxt = ryn_r; vxn_nxt = vxn_r; vyn_nxt = vyn_r;
    p1_nxt = p1_r; p2_nxt = p2_r; sv_nxt = sv_r;
    hx_nxt = hx_r; hy_nxt = hy_r; ex_nxt = ex_r; ey_nxt = ey_r;
    short_nxt = short_r;
    stat_nxt = stat_r;
    out_vld_nxt = out_vld_r && !out_tready;
    o_valid_nxt = o_valid_r; o_stat_nxt = o_stat_r; o_hull_nxt = o_hull_r;
    req.rd_en   = 1'b0;
    req.rd_addr = j_r;
    req.wr_en   = 1'b0;
    req.wr_addr = dc_r[IW-1:0];
    req.wr_data = {x_r, y_r};

    case (state_r)
      cpvc_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          x_nxt    = in_tdata[31:0];
          y_nxt    = in_tdata[63:32];
          last_nxt = in_tlast;
          raw_nxt  = (raw_r == CW'(cpvc_pkg::RAW_SAT)) ? raw_r : raw_r + 4'd1;
          j_nxt    = '0;
          if ((raw_r < CW'(cpvc_pkg::MAX_VERTS)) && (dc_r < CW'(cpvc_pkg::MAX_VERTS))) begin
            state_nxt = (dc_r == '0) ? cpvc_pkg::ST_WRITE : cpvc_pkg::ST_W_RD;
          end else begin
            state_nxt = in_tlast ? cpvc_pkg::ST_E_CHK : cpvc_pkg::ST_IDLE;
          end
        end
      end
      cpvc_pkg::ST_W_RD: begin
        req.rd_en = 1'b1;
        state_nxt = cpvc_pkg::ST_W_DIFF;
      end
      cpvc_pkg::ST_W_DIFF: begin
        ra_nxt = mag33(d_wx);
        rb_nxt = mag33(d_wy);
        state_nxt = cpvc_pkg::ST_W_M1;
      end
      cpvc_pkg::ST_W_M1: begin
        p1_nxt = prod;
        state_nxt = cpvc_pkg::ST_W_M2;
      end
      cpvc_pkg::ST_W_M2: begin
        p2_nxt = prod;
        state_nxt = cpvc_pkg::ST_W_CMP;
      end
      cpvc_pkg::ST_W_CMP: begin
        if (!sum[64] && (sum[63:0] < weld_r)) begin
          state_nxt = last_r ? cpvc_pkg::ST_E_CHK : cpvc_pkg::ST_IDLE;
        end else if (lastj) begin
          state_nxt = cpvc_pkg::ST_WRITE;
        end else begin
          j_nxt = j_r + 1'b1;
          state_nxt = cpvc_pkg::ST_W_RD;
        end
      end
      cpvc_pkg::ST_WRITE: begin
        req.wr_en = 1'b1;
        dc_nxt = dc_r + 4'd1;
        state_nxt = last_r ? cpvc_pkg::ST_E_CHK : cpvc_pkg::ST_IDLE;
      end
      cpvc_pkg::ST_E_CHK: begin
        m_nxt = '0;
        short_nxt = 1'b0;
        j_nxt = '0;
        if ((raw_r < 4'd3) || (raw_r > CW'(cpvc_pkg::MAX_VERTS))) begin
          stat_nxt = cpvc_pkg::STAT_COUNT;
          state_nxt = cpvc_pkg::ST_OUT;
        end else if (dc_r < 4'd3) begin
          stat_nxt = cpvc_pkg::STAT_FEW;
          state_nxt = cpvc_pkg::ST_OUT;
        end else begin
          req.rd_en = 1'b1;
          req.rd_addr = '0;
          state_nxt = cpvc_pkg::ST_F_CMP;
        end
      end
      cpvc_pkg::ST_F_CMP: begin
        if (better) begin
          ih_nxt = j_r;
          hx_nxt = rd_x;
          hy_nxt = rd_y;
          i0_nxt = j_r;
        end else begin
          i0_nxt = ih_r;
        end
        if (lastj) begin
          state_nxt = cpvc_pkg::ST_H_TOP;
        end else begin
          j_nxt = j_r + 1'b1;
          req.rd_en = 1'b1;
          req.rd_addr = j_r + 1'b1;
        end
      end
      cpvc_pkg::ST_H_TOP: begin
        if (m_r == CW'(cpvc_pkg::MAX_VERTS)) begin
          stat_nxt = cpvc_pkg::STAT_OVF;
          state_nxt = cpvc_pkg::ST_OUT;
        end else begin
          req.rd_en = 1'b1;
          req.rd_addr = '0;
          state_nxt = cpvc_pkg::ST_H_FIRST;
        end
      end
      cpvc_pkg::ST_H_FIRST: begin
        ie_nxt = '0;
        ex_nxt = rd_x;
        ey_nxt = rd_y;
        j_nxt = IW'(1);
        req.rd_en = 1'b1;
        req.rd_addr = IW'(1);
        state_nxt = cpvc_pkg::ST_H_J;
      end
      cpvc_pkg::ST_H_J: begin
        x_nxt = rd_x;
        y_nxt = rd_y;
        if (ie_r == ih_r) begin
          ie_nxt = j_r;
          ex_nxt = rd_x;
          ey_nxt = rd_y;
          state_nxt = cpvc_pkg::ST_H_NEXT;
        end else begin
          ra_nxt = mag33(d_rx);
          rb_nxt = mag33(d_ry);
          va_nxt = mag33(d_vx);
          vb_nxt = mag33(d_vy);
          rxn_nxt = d_rx[32];
          ryn_nxt = d_ry[32];
          vxn_nxt = d_vx[32];
          vyn_nxt = d_vy[32];
          state_nxt = cpvc_pkg::ST_H_CA;
        end
      end
      cpvc_pkg::ST_H_CA: begin
        p1_nxt = prod;
        state_nxt = cpvc_pkg::ST_H_CB;
      end
      cpvc_pkg::ST_H_CB: begin
        p2_nxt = prod;
        state_nxt = cpvc_pkg::ST_H_CS;
      end
      cpvc_pkg::ST_H_CS: begin
        if (c_neg) begin
          ie_nxt = j_r;
          ex_nxt = x_r;
          ey_nxt = y_r;
          state_nxt = cpvc_pkg::ST_H_NEXT;
        end else if (c_zero) begin
          state_nxt = cpvc_pkg::ST_H_L1;
        end else begin
          state_nxt = cpvc_pkg::ST_H_NEXT;
        end
      end
      cpvc_pkg::ST_H_L1: begin
        p1_nxt = prod;
        state_nxt = cpvc_pkg::ST_H_L2;
      end
      cpvc_pkg::ST_H_L2: begin
        p2_nxt = prod;
        state_nxt = cpvc_pkg::ST_H_L3;
      end
      cpvc_pkg::ST_H_L3: begin
        sv_nxt = sum;
        p1_nxt = prod;
        state_nxt = cpvc_pkg::ST_H_L4;
      end
      cpvc_pkg::ST_H_L4: begin
        p2_nxt = prod;
        state_nxt = cpvc_pkg::ST_H_LC;
      end
      cpvc_pkg::ST_H_LC: begin
        if (sv_r > sum) begin
          ie_nxt = j_r;
          ex_nxt = x_r;
          ey_nxt = y_r;
        end
        state_nxt = cpvc_pkg::ST_H_NEXT;
      end
      cpvc_pkg::ST_H_NEXT: begin
        if (lastj) begin
          state_nxt = cpvc_pkg::ST_H_ED;
        end else begin
          j_nxt = j_r + 1'b1;
          req.rd_en = 1'b1;
          req.rd_addr = j_r + 1'b1;
          state_nxt = cpvc_pkg::ST_H_J;
        end
      end
      cpvc_pkg::ST_H_ED: begin
        ra_nxt = mag33(d_rx);
        rb_nxt = mag33(d_ry);
        state_nxt = cpvc_pkg::ST_H_E1;
      end
      cpvc_pkg::ST_H_E1: begin
        p1_nxt = prod;
        state_nxt = cpvc_pkg::ST_H_E2;
      end
      cpvc_pkg::ST_H_E2: begin
        p2_nxt = prod;
        state_nxt = cpvc_pkg::ST_H_EC;
      end
      cpvc_pkg::ST_H_EC: begin
        if (!sum[64] && (sum[63:0] <= edge_r)) begin
          short_nxt = 1'b1;
        end
        m_nxt = m_r + 4'd1;
        ih_nxt = ie_r;
        hx_nxt = ex_r;
        hy_nxt = ey_r;
        state_nxt = (ie_r == i0_r) ? cpvc_pkg::ST_H_FIN : cpvc_pkg::ST_H_TOP;
      end
      cpvc_pkg::ST_H_FIN: begin
        if (m_r < 4'd3) begin
          stat_nxt = cpvc_pkg::STAT_DEGEN;
        end else if (short_r) begin
          stat_nxt = cpvc_pkg::STAT_SHORT;
        end else begin
          stat_nxt = cpvc_pkg::STAT_OK;
        end
        state_nxt = cpvc_pkg::ST_OUT;
      end
      cpvc_pkg::ST_OUT: begin
        if (!out_vld_r || out_tready) begin
          out_vld_nxt = 1'b1;
          o_valid_nxt = (stat_r == cpvc_pkg::STAT_OK);
          o_stat_nxt = stat_r;
          o_hull_nxt = m_r;
          raw_nxt = '0;
          dc_nxt = '0;
          state_nxt = cpvc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = cpvc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= cpvc_pkg::ST_IDLE;
      raw_r     <= '0;
      dc_r      <= '0;
      out_vld_r <= 1'b0;
      weld_r    <= 64'd26844;
      edge_r    <= 64'd0;
    end else begin
      state_r   <= state_nxt;
      raw_r     <= raw_nxt;
      dc_r      <= dc_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          cpvc_pkg::CFG_WELD: weld_r <= cfg_wdata;
          cpvc_pkg::CFG_EDGE: edge_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt; y_r <= y_nxt; last_r <= last_nxt; m_r <= m_nxt;
    j_r <= j_nxt; ie_r <= ie_nxt; ih_r <= ih_nxt; i0_r <= i0_nxt;
    ra_r <= ra_nxt; rb_r <= rb_nxt; va_r <= va_nxt; vb_r <= vb_nxt;
    rxn_r <= rxn_nxt; ryn_r <= ryn_nxt; vxn_r <= vxn_nxt; vyn_r <= vyn_nxt;
    p1_r <= p1_nxt; p2_r <= p2_nxt; sv_r <= sv_nxt;
    hx_r <= hx_nxt; hy_r <= hy_nxt; ex_r <= ex_nxt; ey_r <= ey_nxt;
    short_r <= short_nxt; stat_r <= stat_nxt;
    o_valid_r <= o_valid_nxt; o_stat_r <= o_stat_nxt; o_hull_r <= o_hull_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {o_hull_r, o_stat_r, o_valid_r};

endmodule

@@ sv/cpvc_vert_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpvc_vert_ram
// Kept-vertex store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module cpvc_vert_ram (
  input  logic                       clk,
  input  cpvc_pkg::ram_req_t         req,
  output logic [cpvc_pkg::VERT_W-1:0] rd_data
);

  logic [cpvc_pkg::VERT_W-1:0] mem [cpvc_pkg::MAX_VERTS];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

@@ sv/cpvc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpvc_checker
// Port-level checks on the result channel of the validity checker.
// ----------------------------------------------------------------------------
module cpvc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word dropped or changed while stalled");

  a_valid_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[0] == (out_tdata[3:1] == cpvc_pkg::STAT_OK)))
    else $error("valid flag disagrees with status");

  a_early_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[3:1] == cpvc_pkg::STAT_COUNT ||
                   out_tdata[3:1] == cpvc_pkg::STAT_FEW) |-> out_tdata[7:4] == 4'd0)
    else $error("hull count nonzero on early failure");

  a_ok_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[7:4] >= 4'd3 && out_tdata[7:4] <= 4'd8)
    else $error("valid hull with bad vertex count");

endmodule

bind convex_polygon_validity_check cpvc_checker u_cpvc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
